// ===== rtl/sgi_pkg.sv =====
// ----------------------------------------------------------------------------
// sgi_pkg: shared constants for the segment intersection unit
// Operation codes, rectangle side codes and the default coordinate width.
// ----------------------------------------------------------------------------
package sgi_pkg;

   localparam int COORD_BITS_DEFAULT = 16;

   localparam logic [1:0] MODE_SEG_HIT    = 2'd0;
   localparam logic [1:0] MODE_RECT_HIT   = 2'd1;
   localparam logic [1:0] MODE_SEG_POINT  = 2'd2;
   localparam logic [1:0] MODE_RECT_POINT = 2'd3;

   localparam logic [2:0] SIDE_LEFT   = 3'd1;
   localparam logic [2:0] SIDE_RIGHT  = 3'd2;
   localparam logic [2:0] SIDE_TOP    = 3'd3;
   localparam logic [2:0] SIDE_BOTTOM = 3'd4;

endpackage

// ===== rtl/sgi_channels_if.sv =====
// ----------------------------------------------------------------------------
// sgi channels: request and response interfaces
// Valid/ready channels that carry one query and one result per transaction.
// ----------------------------------------------------------------------------
interface sgi_req_if import sgi_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) ();
   logic                         valid;
   logic                         ready;
   logic [1:0]                   mode;
   logic signed [COORD_BITS-1:0] seg_x1;
   logic signed [COORD_BITS-1:0] seg_y1;
   logic signed [COORD_BITS-1:0] seg_x2;
   logic signed [COORD_BITS-1:0] seg_y2;
   logic signed [COORD_BITS-1:0] other_a_x;
   logic signed [COORD_BITS-1:0] other_a_y;
   logic signed [COORD_BITS-1:0] other_b_x;
   logic signed [COORD_BITS-1:0] other_b_y;
   logic [2:0]                   side;

   modport source (
      output valid, mode, seg_x1, seg_y1, seg_x2, seg_y2,
             other_a_x, other_a_y, other_b_x, other_b_y, side,
      input  ready
   );
   modport sink (
      input  valid, mode, seg_x1, seg_y1, seg_x2, seg_y2,
             other_a_x, other_a_y, other_b_x, other_b_y, side,
      output ready
   );
endinterface

interface sgi_rsp_if import sgi_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) ();
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic                         point_valid;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;

   modport source (
      output valid, hit, point_valid, point_x, point_y,
      input  ready
   );
   modport sink (
      input  valid, hit, point_valid, point_x, point_y,
      output ready
   );
endinterface

// ===== rtl/segment_intersection_unit_top.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_unit_top: pipelined exact segment and rectangle tests
// Path: stages 1 to 3, the division pipeline, then the output register.
// Throughput: one transaction per cycle; occupied stages stall only
// when the last register holds an untaken response.  Sync reset clears valids.
// ----------------------------------------------------------------------------
module segment_intersection_unit_top import sgi_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   sgi_req_if.sink   req_ch,
   sgi_rsp_if.source rsp_ch
);

   // Widths. E holds a rectangle's far corner, D every coordinate difference,
   // P a product of two differences, N a cross-product sum (den, na, nb).
   localparam int C    = COORD_BITS;
   localparam int E    = C + 1;
   localparam int D    = C + 2;
   localparam int P    = 2 * D;
   localparam int N    = P + 1;
   localparam int M    = C + 1;
   localparam int Q    = C + 2;
   localparam int F    = C + 4;
   localparam int LAST = C + 1;

   // ------------------------------------------------------------------------
   // Stage 1: build the four candidate segments and all differences.
   // Lane 0 is the segment whose point may be reported: the second segment in
   // modes 0 and 2, the left side in mode 1, and the chosen side in mode 3.
   // Lanes 1 to 3 are the right, top and bottom sides for the rectangle test.
   // ------------------------------------------------------------------------
   logic signed [E-1:0] axe, aye, bxe, bye, rr, rb;
   logic signed [E-1:0] lx3 [4];
   logic signed [E-1:0] ly3 [4];
   logic signed [E-1:0] lx4 [4];
   logic signed [E-1:0] ly4 [4];
   logic                side_ok_in;

   logic signed [D-1:0] dx_in, dy_in;
   logic signed [D-1:0] ex_in [4];
   logic signed [D-1:0] ey_in [4];
   logic signed [D-1:0] fx_in [4];
   logic signed [D-1:0] fy_in [4];

   always_comb begin
      axe = E'(req_ch.other_a_x);
      aye = E'(req_ch.other_a_y);
      bxe = E'(req_ch.other_b_x);
      bye = E'(req_ch.other_b_y);
      rr  = axe + bxe;
      rb  = aye + bye;

      // Right, top and bottom sides.
      lx3[1] = rr;  ly3[1] = aye; lx4[1] = rr; ly4[1] = rb;
      lx3[2] = axe; ly3[2] = aye; lx4[2] = rr; ly4[2] = aye;
      lx3[3] = axe; ly3[3] = rb;  lx4[3] = rr; ly4[3] = rb;

      // Lane 0 defaults to the left side.
      lx3[0] = axe; ly3[0] = aye; lx4[0] = axe; ly4[0] = rb;
      unique case (req_ch.mode)
         MODE_SEG_HIT, MODE_SEG_POINT: begin
            lx3[0] = axe; ly3[0] = aye; lx4[0] = bxe; ly4[0] = bye;
         end
         MODE_RECT_HIT: begin
         end
         MODE_RECT_POINT: begin
            case (req_ch.side)
               SIDE_RIGHT: begin
                  lx3[0] = lx3[1]; ly3[0] = ly3[1]; lx4[0] = lx4[1]; ly4[0] = ly4[1];
               end
               SIDE_TOP: begin
                  lx3[0] = lx3[2]; ly3[0] = ly3[2]; lx4[0] = lx4[2]; ly4[0] = ly4[2];
               end
               SIDE_BOTTOM: begin
                  lx3[0] = lx3[3]; ly3[0] = ly3[3]; lx4[0] = lx4[3]; ly4[0] = ly4[3];
               end
               default: begin
               end
            endcase
         end
      endcase

      side_ok_in = (req_ch.side >= SIDE_LEFT) && (req_ch.side <= SIDE_BOTTOM);

      dx_in = D'(req_ch.seg_x2) - D'(req_ch.seg_x1);
      dy_in = D'(req_ch.seg_y2) - D'(req_ch.seg_y1);
      for (int l = 0; l < 4; l++) begin
         ex_in[l] = D'(lx4[l]) - D'(lx3[l]);
         ey_in[l] = D'(ly4[l]) - D'(ly3[l]);
         fx_in[l] = D'(req_ch.seg_x1) - D'(lx3[l]);
         fy_in[l] = D'(req_ch.seg_y1) - D'(ly3[l]);
      end
   end

   // Stage enables: a stage loads when it is empty or its successor moves.
   logic en_s1, en_s2, en_s3, en_out;
   logic dv_en [0:LAST];

   logic                s1_valid_ff;
   logic [1:0]          s1_mode_ff;
   logic                s1_side_ok_ff;
   logic signed [C-1:0] s1_x1_ff, s1_y1_ff;
   logic signed [D-1:0] s1_dx_ff, s1_dy_ff;
   logic signed [D-1:0] s1_ex_ff [4];
   logic signed [D-1:0] s1_ey_ff [4];
   logic signed [D-1:0] s1_fx_ff [4];
   logic signed [D-1:0] s1_fy_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en_s1) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (en_s1) begin
         s1_mode_ff    <= req_ch.mode;
         s1_side_ok_ff <= side_ok_in;
         s1_x1_ff      <= req_ch.seg_x1;
         s1_y1_ff      <= req_ch.seg_y1;
         s1_dx_ff      <= dx_in;
         s1_dy_ff      <= dy_in;
         s1_ex_ff      <= ex_in;
         s1_ey_ff      <= ey_in;
         s1_fx_ff      <= fx_in;
         s1_fy_ff      <= fy_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: the six cross products of every lane.
   // ------------------------------------------------------------------------
   logic signed [P-1:0] pa_in [4];
   logic signed [P-1:0] pb_in [4];
   logic signed [P-1:0] pc_in [4];
   logic signed [P-1:0] pd_in [4];
   logic signed [P-1:0] pe_in [4];
   logic signed [P-1:0] pf_in [4];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         pa_in[l] = P'(s1_ey_ff[l]) * P'(s1_dx_ff);
         pb_in[l] = P'(s1_ex_ff[l]) * P'(s1_dy_ff);
         pc_in[l] = P'(s1_ex_ff[l]) * P'(s1_fy_ff[l]);
         pd_in[l] = P'(s1_ey_ff[l]) * P'(s1_fx_ff[l]);
         pe_in[l] = P'(s1_dx_ff) * P'(s1_fy_ff[l]);
         pf_in[l] = P'(s1_dy_ff) * P'(s1_fx_ff[l]);
      end
   end

   logic                s2_valid_ff;
   logic [1:0]          s2_mode_ff;
   logic                s2_side_ok_ff;
   logic signed [C-1:0] s2_x1_ff, s2_y1_ff;
   logic signed [D-1:0] s2_dx_ff, s2_dy_ff;
   logic signed [P-1:0] s2_pa_ff [4];
   logic signed [P-1:0] s2_pb_ff [4];
   logic signed [P-1:0] s2_pc_ff [4];
   logic signed [P-1:0] s2_pd_ff [4];
   logic signed [P-1:0] s2_pe_ff [4];
   logic signed [P-1:0] s2_pf_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en_s2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en_s2) begin
         s2_mode_ff    <= s1_mode_ff;
         s2_side_ok_ff <= s1_side_ok_ff;
         s2_x1_ff      <= s1_x1_ff;
         s2_y1_ff      <= s1_y1_ff;
         s2_dx_ff      <= s1_dx_ff;
         s2_dy_ff      <= s1_dy_ff;
         s2_pa_ff      <= pa_in;
         s2_pb_ff      <= pb_in;
         s2_pc_ff      <= pc_in;
         s2_pd_ff      <= pd_in;
         s2_pe_ff      <= pe_in;
         s2_pf_ff      <= pf_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: denominator and both numerators of every lane.
   // ------------------------------------------------------------------------
   logic signed [N-1:0] den_in [4];
   logic signed [N-1:0] na_in  [4];
   logic signed [N-1:0] nb_in  [4];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         den_in[l] = N'(s2_pa_ff[l]) - N'(s2_pb_ff[l]);
         na_in[l]  = N'(s2_pc_ff[l]) - N'(s2_pd_ff[l]);
         nb_in[l]  = N'(s2_pe_ff[l]) - N'(s2_pf_ff[l]);
      end
   end

   logic                s3_valid_ff;
   logic [1:0]          s3_mode_ff;
   logic                s3_side_ok_ff;
   logic signed [C-1:0] s3_x1_ff, s3_y1_ff;
   logic signed [D-1:0] s3_dx_ff, s3_dy_ff;
   logic signed [N-1:0] s3_den_ff [4];
   logic signed [N-1:0] s3_na_ff  [4];
   logic signed [N-1:0] s3_nb_ff  [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en_s3) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en_s3) begin
         s3_mode_ff    <= s2_mode_ff;
         s3_side_ok_ff <= s2_side_ok_ff;
         s3_x1_ff      <= s2_x1_ff;
         s3_y1_ff      <= s2_y1_ff;
         s3_dx_ff      <= s2_dx_ff;
         s3_dy_ff      <= s2_dy_ff;
         s3_den_ff     <= den_in;
         s3_na_ff      <= na_in;
         s3_nb_ff      <= nb_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: exact range tests. With den positive both numerators must lie
   // in [0, den]; with den negative they must lie in [den, 0]. This avoids a
   // negation before the compare. Lane 0 is also made positive for division.
   // ------------------------------------------------------------------------
   logic          lane_hit [4];
   logic          hit_in, pv_in;
   logic [N-1:0]  den_abs_in, na_abs_in;
   logic [M-1:0]  dxm_in, dym_in;

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (s3_den_ff[l] > 0) begin
            lane_hit[l] = (s3_na_ff[l] >= 0) && (s3_na_ff[l] <= s3_den_ff[l]) &&
                          (s3_nb_ff[l] >= 0) && (s3_nb_ff[l] <= s3_den_ff[l]);
         end else if (s3_den_ff[l] < 0) begin
            lane_hit[l] = (s3_na_ff[l] <= 0) && (s3_na_ff[l] >= s3_den_ff[l]) &&
                          (s3_nb_ff[l] <= 0) && (s3_nb_ff[l] >= s3_den_ff[l]);
         end else begin
            lane_hit[l] = 1'b0;
         end
      end

      unique case (s3_mode_ff)
         MODE_SEG_HIT, MODE_SEG_POINT: hit_in = lane_hit[0];
         MODE_RECT_HIT:   hit_in = lane_hit[0] | lane_hit[1] | lane_hit[2] | lane_hit[3];
         MODE_RECT_POINT: hit_in = lane_hit[0] & s3_side_ok_ff;
      endcase
      pv_in = hit_in && ((s3_mode_ff == MODE_SEG_POINT) || (s3_mode_ff == MODE_RECT_POINT));

      if (s3_den_ff[0] < 0) begin
         den_abs_in = N'(-s3_den_ff[0]);
         na_abs_in  = N'(-s3_na_ff[0]);
      end else begin
         den_abs_in = N'(s3_den_ff[0]);
         na_abs_in  = N'(s3_na_ff[0]);
      end
      dxm_in = (s3_dx_ff < 0) ? M'(-s3_dx_ff) : M'(s3_dx_ff);
      dym_in = (s3_dy_ff < 0) ? M'(-s3_dy_ff) : M'(s3_dy_ff);
   end

   // ------------------------------------------------------------------------
   // Division pipeline: na * |d| / den, one bit of |d| per stage, MSB first.
   // Since na <= den and the running remainder stays below den, each step
   // adds na at most once and subtracts den at most twice.
   // ------------------------------------------------------------------------
   logic                dv_valid_ff [0:LAST];
   logic                dv_hit_ff   [0:LAST];
   logic                dv_pv_ff    [0:LAST];
   logic [N-1:0]        dv_den_ff   [0:LAST];
   logic [N-1:0]        dv_na_ff    [0:LAST];
   logic [M-1:0]        dv_dxm_ff   [0:LAST];
   logic [M-1:0]        dv_dym_ff   [0:LAST];
   logic                dv_xneg_ff  [0:LAST];
   logic                dv_yneg_ff  [0:LAST];
   logic signed [C-1:0] dv_x1_ff    [0:LAST];
   logic signed [C-1:0] dv_y1_ff    [0:LAST];
   logic [N-1:0]        dv_rx_ff    [0:LAST];
   logic [N-1:0]        dv_ry_ff    [0:LAST];
   logic [Q-1:0]        dv_qx_ff    [0:LAST];
   logic [Q-1:0]        dv_qy_ff    [0:LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (dv_en[0]) begin
         dv_valid_ff[0] <= s3_valid_ff;
      end
      if (dv_en[0]) begin
         dv_hit_ff[0]  <= hit_in;
         dv_pv_ff[0]   <= pv_in;
         dv_den_ff[0]  <= den_abs_in;
         dv_na_ff[0]   <= na_abs_in;
         dv_dxm_ff[0]  <= dxm_in;
         dv_dym_ff[0]  <= dym_in;
         dv_xneg_ff[0] <= s3_dx_ff < 0;
         dv_yneg_ff[0] <= s3_dy_ff < 0;
         dv_x1_ff[0]   <= s3_x1_ff;
         dv_y1_ff[0]   <= s3_y1_ff;
         dv_rx_ff[0]   <= '0;
         dv_ry_ff[0]   <= '0;
         dv_qx_ff[0]   <= '0;
         dv_qy_ff[0]   <= '0;
      end
   end

   for (genvar j = 0; j < LAST; j++) begin : g_div
      logic [N+1:0] r2x, r2y, d1, d2;
      logic [N-1:0] rx_in, ry_in;
      logic [1:0]   digx, digy;
      logic [Q-1:0] qx_in, qy_in;

      always_comb begin
         d1  = (N+2)'(dv_den_ff[j]);
         d2  = {1'b0, dv_den_ff[j], 1'b0};
         r2x = {1'b0, dv_rx_ff[j], 1'b0} +
               (dv_dxm_ff[j][C-j] ? (N+2)'(dv_na_ff[j]) : '0);
         r2y = {1'b0, dv_ry_ff[j], 1'b0} +
               (dv_dym_ff[j][C-j] ? (N+2)'(dv_na_ff[j]) : '0);
         if (r2x >= d2) begin
            digx  = 2'd2;
            rx_in = N'(r2x - d2);
         end else if (r2x >= d1) begin
            digx  = 2'd1;
            rx_in = N'(r2x - d1);
         end else begin
            digx  = 2'd0;
            rx_in = N'(r2x);
         end
         if (r2y >= d2) begin
            digy  = 2'd2;
            ry_in = N'(r2y - d2);
         end else if (r2y >= d1) begin
            digy  = 2'd1;
            ry_in = N'(r2y - d1);
         end else begin
            digy  = 2'd0;
            ry_in = N'(r2y);
         end
         qx_in = {dv_qx_ff[j][Q-2:0], 1'b0} + Q'(digx);
         qy_in = {dv_qy_ff[j][Q-2:0], 1'b0} + Q'(digy);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (dv_en[j+1]) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
         if (dv_en[j+1]) begin
            dv_hit_ff[j+1]  <= dv_hit_ff[j];
            dv_pv_ff[j+1]   <= dv_pv_ff[j];
            dv_den_ff[j+1]  <= dv_den_ff[j];
            dv_na_ff[j+1]   <= dv_na_ff[j];
            dv_dxm_ff[j+1]  <= dv_dxm_ff[j];
            dv_dym_ff[j+1]  <= dv_dym_ff[j];
            dv_xneg_ff[j+1] <= dv_xneg_ff[j];
            dv_yneg_ff[j+1] <= dv_yneg_ff[j];
            dv_x1_ff[j+1]   <= dv_x1_ff[j];
            dv_y1_ff[j+1]   <= dv_y1_ff[j];
            dv_rx_ff[j+1]   <= rx_in;
            dv_ry_ff[j+1]   <= ry_in;
            dv_qx_ff[j+1]   <= qx_in;
            dv_qy_ff[j+1]   <= qy_in;
         end
      end

      assign dv_en[j] = !dv_valid_ff[j] || dv_en[j+1];
   end

   assign dv_en[LAST] = !dv_valid_ff[LAST] || en_out;
   assign en_s3       = !s3_valid_ff || dv_en[0];
   assign en_s2       = !s2_valid_ff || en_s3;
   assign en_s1       = !s1_valid_ff || en_s2;
   assign req_ch.ready = en_s1;

   // ------------------------------------------------------------------------
   // Output stage: apply the sign of the direction, add the start point and
   // round the exact value toward zero. A floored sum with a
   // nonzero remainder is one below the truncated value when the sum is
   // negative, so one is added back there.
   // ------------------------------------------------------------------------
   logic signed [Q:0]   qxs, qys, flx, fly;
   logic signed [F-1:0] sx, sy;
   logic                rxnz, rynz;
   logic [C-1:0]        px_in, py_in;

   always_comb begin
      rxnz = dv_rx_ff[LAST] != '0;
      rynz = dv_ry_ff[LAST] != '0;
      qxs  = $signed({1'b0, dv_qx_ff[LAST]});
      qys  = $signed({1'b0, dv_qy_ff[LAST]});
      flx  = dv_xneg_ff[LAST] ? (rxnz ? ~qxs : -qxs) : qxs;
      fly  = dv_yneg_ff[LAST] ? (rynz ? ~qys : -qys) : qys;
      sx   = F'(dv_x1_ff[LAST]) + F'(flx);
      sy   = F'(dv_y1_ff[LAST]) + F'(fly);
      if (rxnz && (sx < 0)) begin
         sx = sx + F'(1);
      end
      if (rynz && (sy < 0)) begin
         sy = sy + F'(1);
      end
      px_in = dv_pv_ff[LAST] ? sx[C-1:0] : '0;
      py_in = dv_pv_ff[LAST] ? sy[C-1:0] : '0;
   end

   logic         out_valid_ff;
   logic         out_hit_ff, out_pv_ff;
   logic [C-1:0] out_px_ff, out_py_ff;

   assign en_out = !out_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en_out) begin
         out_valid_ff <= dv_valid_ff[LAST];
      end
      if (en_out) begin
         out_hit_ff <= dv_hit_ff[LAST];
         out_pv_ff  <= dv_pv_ff[LAST];
         out_px_ff  <= px_in;
         out_py_ff  <= py_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.hit         = out_hit_ff;
   assign rsp_ch.point_valid = out_pv_ff;
   assign rsp_ch.point_x     = out_px_ff;
   assign rsp_ch.point_y     = out_py_ff;

`ifndef SYNTHESIS
   // A response without a point carries a zero point.
   a_zero_point: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.point_valid |-> rsp_ch.point_x == '0 && rsp_ch.point_y == '0)
      else $error("point fields nonzero without point_valid");

   // A reported point always belongs to a hit.
   a_point_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.point_valid |-> rsp_ch.hit)
      else $error("point_valid without hit");

   // An accepted transaction lands in the first stage.
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> s1_valid_ff)
      else $error("accepted transaction lost at stage 1");
`endif

endmodule
